// ===== rtl/aes_pkg.sv =====
// Package for the AES-128 block encryption core.
// Holds the S-box, round constants, the xtime helper and the state enum.
package aes_pkg;

  typedef enum logic [1:0] {ST_IDLE, ST_KEYX, ST_RUN, ST_OUT} state_t;

  localparam int unsigned Rounds = 10;
  localparam int unsigned KeyWords = 44;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r=8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
      4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
      4'd9: r = 8'h1b; 4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ===== rtl/aes_key_expand.sv =====
// Round-key expansion for the AES-128 core: one 128-bit round key per cycle.
// Depends on aes_pkg for the S-box and round constants.
module aes_key_expand (
  input  logic         clk,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [3:0]   rnd,
  output logic [127:0] rk
);

  logic [127:0] rk_next;
  logic [31:0]  w3;
  logic [31:0]  t;
  logic [31:0]  w0, w1, w2, w3n;

  always_comb begin
    w3 = rk[31:0];
    t  = {aes_pkg::sbox(w3[23:16]) ^ aes_pkg::rcon(rnd), aes_pkg::sbox(w3[15:8]),
          aes_pkg::sbox(w3[7:0]), aes_pkg::sbox(w3[31:24])};
    w0  = rk[127:96] ^ t;
    w1  = rk[95:64] ^ w0;
    w2  = rk[63:32] ^ w1;
    w3n = rk[31:0] ^ w2;
    rk_next = start ? key : {w0, w1, w2, w3n};
  end

  always_ff @(posedge clk) begin
    rk <= rk_next;
  end

endmodule

// ===== rtl/aes_round.sv =====
// One shared AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aes_pkg for the S-box and xtime.
module aes_round (
  input  logic [127:0] din,
  input  logic [127:0] rk,
  input  logic         last,
  output logic [127:0] dout
);

  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [7:0]   m [16];
  logic [7:0]   a0, a1, a2, a3, p;
  logic [127:0] v;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = din[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4 + r] = aes_pkg::sbox(s[((c + r) % 4)*4 + r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
      p = a0 ^ a1 ^ a2 ^ a3;
      m[c*4]   = last ? a0 : (a0 ^ p ^ aes_pkg::xtime(a0 ^ a1));
      m[c*4+1] = last ? a1 : (a1 ^ p ^ aes_pkg::xtime(a1 ^ a2));
      m[c*4+2] = last ? a2 : (a2 ^ p ^ aes_pkg::xtime(a2 ^ a3));
      m[c*4+3] = last ? a3 : (a3 ^ p ^ aes_pkg::xtime(a3 ^ a0));
    end
    for (int i = 0; i < 16; i++) begin
      v[127 - 8*i -: 8] = m[i];
    end
    dout = v ^ rk;
  end

endmodule

// ===== rtl/aes128_block_encrypt_core.sv =====
// Top level of the AES-128 block encryption core.
// Depends on aes_pkg, aes_key_expand and aes_round.
//
// Usage: the key is written through the cfg port (index 0 = key bytes 0..7,
// index 1 = key bytes 8..15). A plaintext beat arrives on s_axis; its
// ciphertext leaves on m_axis. The round keys are generated on the fly by a
// key-expansion unit that steps in lockstep with the shared round unit.
// An accepted beat takes the initial key addition plus ten rounds, one round
// per cycle through the single round unit. The result is moved into an
// output register that holds it until taken. s_axis_tready is high only
// while the core is idle, so one block is in work at a time; with a free
// output register the core is idle again right after the last round.
// When the receiver stalls, the result holds on m_axis while the core takes
// one more beat; that block waits in the round register after its last
// round and no new beat is accepted until the output register frees.
// Reset clears the key to zero, empties the output register and returns the
// core to idle.
module aes128_block_encrypt_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // plain_upper [63:0], plain_lower [127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // cipher_upper [63:0], cipher_lower [127:64]
);

  aes_pkg::state_t state, state_next;
  logic [63:0]  key_upper, key_lower;
  logic [127:0] blk;
  logic [3:0]   rnd, rnd_next;
  logic [127:0] rk;
  logic [127:0] rdout;
  logic         start;
  logic [127:0] res_data;
  logic         res_valid;
  logic         out_free;
  logic         res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg_we) begin
      if (cfg_index) begin
        key_lower <= cfg_data;
      end else begin
        key_upper <= cfg_data;
      end
    end
  end

  assign start = (state == aes_pkg::ST_IDLE);

  aes_key_expand u_kx (
    .clk   (clk),
    .start (start),
    .key   ({key_upper, key_lower}),
    .rnd   (rnd_next),
    .rk    (rk)
  );

  aes_round u_rnd (
    .din  (blk),
    .rk   (rk),
    .last (rnd == 4'(aes_pkg::Rounds)),
    .dout (rdout)
  );

  assign out_free = !res_valid || m_axis_tready;
  assign res_load = out_free &&
                    ((state == aes_pkg::ST_RUN && rnd == 4'(aes_pkg::Rounds)) ||
                     state == aes_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes_pkg::ST_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
    end
  end

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    case (state)
      aes_pkg::ST_IDLE: begin
        rnd_next = 4'd1;
        if (s_axis_tvalid) begin
          state_next = aes_pkg::ST_KEYX;
        end
      end
      aes_pkg::ST_KEYX: begin
        state_next = aes_pkg::ST_RUN;
      end
      aes_pkg::ST_RUN: begin
        if (rnd == 4'(aes_pkg::Rounds)) begin
          state_next = out_free ? aes_pkg::ST_IDLE : aes_pkg::ST_OUT;
        end else begin
          rnd_next = rnd + 4'd1;
        end
      end
      aes_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = aes_pkg::ST_IDLE;
        end
      end
      default: state_next = aes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      aes_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          blk <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        end
      end
      aes_pkg::ST_KEYX: blk <= blk ^ rk;
      aes_pkg::ST_RUN: blk <= rdout;
      default: blk <= blk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data <= (state == aes_pkg::ST_OUT) ? blk : rdout;
    end
  end

  assign s_axis_tready = (state == aes_pkg::ST_IDLE) && !rst;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {res_data[63:0], res_data[127:64]};

endmodule
